FILE: sv/tdcd_pkg.sv
// ----------------------------------------------------------------------------
// tdcd_pkg
// Shared types and constants for the TDC readout word decoder.
// ----------------------------------------------------------------------------
package tdcd_pkg;

    // input beat: one raw FIFO word and the event start mark
    typedef struct packed {
        logic [15:0] data_word;
        logic        first_word;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [1:0]  word_kind;
        logic [12:0] full_address;
        logic [8:0]  hit_time;
        logic        hit_edge;
        logic [7:0]  module_address;
        logic [2:0]  evt_num;
        logic [1:0]  error_code;
    } t_out_beat;

    // status from the seen-map sweeper
    typedef struct packed {
        logic init_busy;
        logic debt_full;
    } t_sweep_stat;

    localparam logic [1:0] KIND_HIT     = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_DROPPED = 2'd3;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_FIRST_NOHDR = 2'd1;
    localparam logic [1:0] ERR_REPEAT_MOD  = 2'd2;
    localparam logic [1:0] ERR_BAD_SETTING = 2'd3;

    localparam logic [3:0] MODE_RESET = 4'd1;

    // header word layout
    localparam int HDR_ID_BIT    = 15;
    localparam int HDR_DW_BIT    = 14;
    localparam int HDR_EDGES_BIT = 10;

    // output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

endpackage

FILE: sv/tdcd_ram.sv
// ----------------------------------------------------------------------------
// tdcd_ram
// Generic RAM: one write port, two registered read ports, read-first.
// ----------------------------------------------------------------------------
module tdcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re_a,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic             i_re_b,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: sv/tdcd_sweep.sv
// ----------------------------------------------------------------------------
// tdcd_sweep
// Seen-map write port owner: clearing pass after reset, background sweep that
// invalidates entries stamped with an old event epoch, write forwarding.
// ----------------------------------------------------------------------------
module tdcd_sweep
    import tdcd_pkg::*;
#(
    parameter int MODULE_COUNT = 256,
    localparam int IW = $clog2(MODULE_COUNT),
    localparam int EW = $clog2(MODULE_COUNT) + 2,
    localparam int DW = $clog2(MODULE_COUNT) + 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // header write from the decode stage
    input  logic          i_item_we,
    input  logic [IW-1:0] i_item_waddr,
    input  logic [EW:0]   i_item_wdata,
    input  logic [EW-1:0] i_epoch,
    input  logic          i_epoch_adv,
    // sweep read port
    output logic [IW-1:0] o_raddr_b,
    input  logic [EW:0]   i_rdata_b,
    // RAM write port
    output logic          o_ram_we,
    output logic [IW-1:0] o_ram_waddr,
    output logic [EW:0]   o_ram_wdata,
    // last write, for forwarding
    output logic          o_fwd_en,
    output logic [IW-1:0] o_fwd_addr,
    output logic [EW:0]   o_fwd_data,
    output t_sweep_stat   o_stat
);

    localparam logic [IW-1:0] LAST_IDX  = IW'(MODULE_COUNT - 1);
    localparam logic [DW-1:0] DEBT_MAX  = DW'(MODULE_COUNT);

    logic          r_init;
    logic [IW-1:0] r_ptr;
    logic          r_sc_valid;
    logic [DW-1:0] r_debt;
    logic          r_fwd_en;
    logic [IW-1:0] r_fwd_addr;
    logic [EW:0]   r_fwd_data;

    logic [EW:0]   sc_data;
    logic          need_clear;
    logic          sc_done;
    logic          advance;
    logic [DW-1:0] n_debt;

    assign sc_data    = (r_fwd_en && r_fwd_addr == r_ptr) ? r_fwd_data : i_rdata_b;
    assign need_clear = sc_data[EW] && (sc_data[EW-1:0] != i_epoch);

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_ptr;
        o_ram_wdata = '0;
        sc_done     = 1'b0;
        if (r_init) begin
            o_ram_we = 1'b1;
        end else if (i_item_we) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = i_item_waddr;
            o_ram_wdata = i_item_wdata;
            // a fresh write to the swept entry retires it as well
            sc_done     = r_sc_valid && (i_item_waddr == r_ptr || !need_clear);
        end else begin
            o_ram_we = r_sc_valid && need_clear;
            sc_done  = r_sc_valid;
        end
    end

    assign advance = r_init || sc_done;

    always_comb begin
        n_debt = r_debt;
        if (i_epoch_adv && !sc_done) begin
            n_debt = r_debt + DW'(1);
        end else if (!i_epoch_adv && sc_done && r_debt != '0) begin
            // sweeping ahead of the epoch earns no credit
            n_debt = r_debt - DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b1;
            r_ptr      <= '0;
            r_sc_valid <= 1'b0;
            r_debt     <= '0;
            r_fwd_en   <= 1'b0;
        end else begin
            if (advance) begin
                r_ptr <= (r_ptr == LAST_IDX) ? '0 : r_ptr + IW'(1);
            end
            if (r_init && r_ptr == LAST_IDX) begin
                r_init <= 1'b0;
            end
            // read data matches the pointer only in the cycle after it settles
            r_sc_valid <= !advance;
            if (!r_init) begin
                r_debt <= n_debt;
            end
            r_fwd_en <= o_ram_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= o_ram_waddr;
        r_fwd_data <= o_ram_wdata;
    end

    assign o_raddr_b      = r_ptr;
    assign o_fwd_en       = r_fwd_en;
    assign o_fwd_addr     = r_fwd_addr;
    assign o_fwd_data     = r_fwd_data;
    assign o_stat.init_busy = r_init;
    assign o_stat.debt_full = (r_debt >= DEBT_MAX);

endmodule

FILE: sv/tdcd_out_fifo.sv
// ----------------------------------------------------------------------------
// tdcd_out_fifo
// Small result queue between the decode stage and the output port.
// ----------------------------------------------------------------------------
module tdcd_out_fifo
    import tdcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_out_beat        i_push_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_beat        o_data,
    output logic [OQ_CW-1:0] o_count
);

    t_out_beat          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]   r_wptr;
    logic [OQ_AW-1:0]   r_rptr;
    logic [OQ_CW-1:0]   r_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + OQ_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + OQ_AW'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + OQ_CW'(1);
            end else if (!i_push && pop) begin
                r_count <= r_count - OQ_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

FILE: sv/tdc_readout_word_decoder.sv
// ----------------------------------------------------------------------------
// tdc_readout_word_decoder
// Header/hit word decoder for a multi-module TDC readout FIFO.
// ----------------------------------------------------------------------------
// Takes one 16-bit word per cycle when the input is not stalled and returns
// one result beat per word via the decode stage register and the result queue.
// The per-module seen map is a RAM read at acceptance and written back in the
// cycle after, with the last write forwarded. Each entry holds an event epoch
// stamp, so an event start clears the map at once; a background sweep retires
// stale stamps using idle write-port cycles. After reset the input is stalled
// while a clearing pass writes every RAM entry. The input is also stalled when
// the sweep falls MODULE_COUNT event starts behind, which only event starts
// outpacing the sweep can cause, and when the four-entry result queue is full.
// ----------------------------------------------------------------------------
module tdc_readout_word_decoder
    import tdcd_pkg::*;
#(
    parameter int MODULE_COUNT = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [3:0] i_cfg_data
);

    localparam int IW = $clog2(MODULE_COUNT);
    localparam int EW = $clog2(MODULE_COUNT) + 2;

    // address modulo MODULE_COUNT by conditional subtraction
    function automatic logic [IW-1:0] mod_index(input logic [7:0] a);
        logic [16:0] v;
        logic [16:0] m;
        v = {9'd0, a};
        for (int k = 7; k >= 0; k--) begin
            m = 17'(MODULE_COUNT) << k;
            if (v >= m) begin
                v = v - m;
            end
        end
        return v[IW-1:0];
    endfunction

    logic [3:0]     r_mode;
    logic           r_s1_valid;
    t_in_beat       r_s1_beat;
    logic [IW-1:0]  r_s1_idx;
    logic           r_failed;
    logic [EW-1:0]  r_epoch;
    logic [7:0]     r_cur_module;

    logic           in_accept;
    logic [EW:0]    rdata_a;
    logic [EW:0]    rdata_b;
    logic [IW-1:0]  raddr_b;
    logic           ram_we;
    logic [IW-1:0]  ram_waddr;
    logic [EW:0]    ram_wdata;
    logic           fwd_en;
    logic [IW-1:0]  fwd_addr;
    logic [EW:0]    fwd_data;
    t_sweep_stat    sweep_stat;
    logic [OQ_CW-1:0] oq_count;
    logic [OQ_CW-1:0] oq_fill;

    logic [15:0]    w;
    logic           first;
    logic [EW:0]    ent;
    logic [EW-1:0]  cur_epoch;
    logic           seen;
    logic           item_we;
    logic           fail_now;
    logic           n_failed;
    logic [7:0]     n_cur_module;
    t_out_beat      res;

    // ---- input side ----
    assign oq_fill    = oq_count + OQ_CW'(r_s1_valid);
    assign o_in_stall = sweep_stat.init_busy || sweep_stat.debt_full ||
                        (oq_fill >= OQ_CW'(OQ_DEPTH));
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    tdcd_ram #(
        .WIDTH (EW + 1),
        .DEPTH (MODULE_COUNT)
    ) u_seen_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re_a    (in_accept),
        .i_raddr_a (mod_index(i_in_data.data_word[7:0])),
        .o_rdata_a (rdata_a),
        .i_re_b    (1'b1),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rdata_b)
    );

    // ---- decode / write-back stage ----
    assign w         = r_s1_beat.data_word;
    assign first     = r_s1_beat.first_word;
    assign ent       = (fwd_en && fwd_addr == r_s1_idx) ? fwd_data : rdata_a;
    assign cur_epoch = first ? r_epoch + EW'(1) : r_epoch;
    assign seen      = !first && ent[EW] && (ent[EW-1:0] == r_epoch);

    always_comb begin
        res          = '0;
        item_we      = 1'b0;
        fail_now     = 1'b0;
        n_cur_module = r_cur_module;
        if (!first && r_failed) begin
            res.word_kind = KIND_DROPPED;
        end else if (w[HDR_ID_BIT]) begin
            res.module_address = w[7:0];
            res.evt_num        = w[13:11];
            if (seen) begin
                res.word_kind  = KIND_ERROR;
                res.error_code = ERR_REPEAT_MOD;
                fail_now       = 1'b1;
            end else begin
                item_we = 1'b1;
                if ({w[HDR_DW_BIT], w[HDR_EDGES_BIT], w[9:8]} != r_mode) begin
                    res.word_kind  = KIND_ERROR;
                    res.error_code = ERR_BAD_SETTING;
                    fail_now       = 1'b1;
                end else begin
                    res.word_kind = KIND_HEADER;
                    n_cur_module  = w[7:0];
                end
            end
        end else if (first) begin
            res.word_kind  = KIND_ERROR;
            res.error_code = ERR_FIRST_NOHDR;
            fail_now       = 1'b1;
        end else begin
            res.word_kind      = KIND_HIT;
            res.hit_time       = w[8:0];
            res.hit_edge       = w[9];
            res.full_address   = {r_cur_module, w[14:10]};
            res.module_address = r_cur_module;
        end
    end

    assign n_failed = (first ? 1'b0 : r_failed) || fail_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_failed     <= 1'b0;
            r_epoch      <= '0;
            r_cur_module <= '0;
        end else begin
            r_s1_valid <= in_accept;
            if (r_s1_valid) begin
                r_failed     <= n_failed;
                r_epoch      <= cur_epoch;
                r_cur_module <= n_cur_module;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_beat <= i_in_data;
            r_s1_idx  <= mod_index(i_in_data.data_word[7:0]);
        end
    end

    tdcd_sweep #(
        .MODULE_COUNT (MODULE_COUNT)
    ) u_sweep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_we    (r_s1_valid && item_we),
        .i_item_waddr (r_s1_idx),
        .i_item_wdata ({1'b1, cur_epoch}),
        .i_epoch      (r_epoch),
        .i_epoch_adv  (r_s1_valid && first),
        .o_raddr_b    (raddr_b),
        .i_rdata_b    (rdata_b),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_fwd_en     (fwd_en),
        .o_fwd_addr   (fwd_addr),
        .o_fwd_data   (fwd_data),
        .o_stat       (sweep_stat)
    );

    tdcd_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_data (res),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_out_data),
        .o_count     (oq_count)
    );

endmodule
